>>> hw/rtl/lch_pkg.sv
// Shared types, constants and digit functions for the card number Luhn checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lch_pkg;

    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned STATUS_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [COUNT_W-1:0] LEN_MIN = 5'd13;
    localparam logic [COUNT_W-1:0] LEN_MAX = 5'd16;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_PREFIX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SUM = 2'd3;

    // Digits that the prefix check looks for
    localparam logic [DIGIT_W-1:0] PFX_VISA = 4'd4;
    localparam logic [DIGIT_W-1:0] PFX_MC = 4'd5;
    localparam logic [DIGIT_W-1:0] PFX_DISC = 4'd6;
    localparam logic [DIGIT_W-1:0] PFX_AMEX_HI = 4'd3;
    localparam logic [DIGIT_W-1:0] PFX_AMEX_LO = 4'd7;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic                valid_res;
        logic [STATUS_W-1:0] status;
    } lch_result_t;

    // Doubled digit with its decimal digits summed, reduced modulo 10.
    // Codes above nine are used as given, as the digit stream is unchecked.
    function automatic digit_t doubled_digit(input digit_t d);
        digit_t r;
        begin
            case (d)
                4'd0:    r = 4'd0;
                4'd1:    r = 4'd2;
                4'd2:    r = 4'd4;
                4'd3:    r = 4'd6;
                4'd4:    r = 4'd8;
                4'd5:    r = 4'd1;
                4'd6:    r = 4'd3;
                4'd7:    r = 4'd5;
                4'd8:    r = 4'd7;
                4'd9:    r = 4'd9;
                4'd10:   r = 4'd2;
                4'd11:   r = 4'd4;
                4'd12:   r = 4'd6;
                4'd13:   r = 4'd8;
                4'd14:   r = 4'd0;
                4'd15:   r = 4'd3;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

    // Plain digit reduced modulo 10.
    function automatic digit_t single_digit(input digit_t d);
        begin
            return (d > 4'd9) ? digit_t'(d - 4'd10) : d;
        end
    endfunction

    // Add two values below ten, modulo 10.
    function automatic digit_t add_mod10(input digit_t a, input digit_t b);
        logic [DIGIT_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s > 5'd9)
            begin
                s = s - 5'd10;
            end
            return s[DIGIT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lch_in_reg.sv
// Input register stage of the Luhn checker: holds one digit beat.
// Depends on lch_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lch_in_reg
    import lch_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   digit_valid,
    output logic        digit_ready,
    input  wire digit_t digit,
    input  wire logic   last,
    input  wire logic   advance,
    output logic        hold_valid,
    output digit_t      hold_digit,
    output logic        hold_last
);

    logic   valid_reg;
    digit_t digit_reg;
    logic   last_reg;

    // A new beat is taken when the stage is empty or its beat moves on.
    assign digit_ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (digit_ready)
        begin
            valid_reg <= digit_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (digit_ready && digit_valid)
        begin
            digit_reg <= digit;
            last_reg <= last;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_digit = digit_reg;
    assign hold_last = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lch_core.sv
// Running Luhn state and the final checks of the card number checker.
// Depends on lch_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lch_core
    import lch_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   fire,
    input  wire digit_t d,
    input  wire logic   is_last,
    output lch_result_t result
);

    logic [COUNT_W-1:0] count_reg, count_next;
    digit_t first_reg, first_next;
    digit_t second_reg, second_next;
    digit_t sum_even_reg, sum_even_next;
    digit_t sum_odd_reg, sum_odd_next;

    digit_t dbl;
    digit_t sgl;
    digit_t chk;
    logic   prefix_ok;
    logic [STATUS_W-1:0] status;

    // Fold the digit into both sums and capture the first two digits.
    always_comb
    begin
        dbl = doubled_digit(d);
        sgl = single_digit(d);
        first_next = (count_reg == '0) ? d : first_reg;
        second_next = (count_reg == COUNT_W'(1)) ? d : second_reg;
        if (!count_reg[0])
        begin
            sum_even_next = add_mod10(sum_even_reg, dbl);
            sum_odd_next = add_mod10(sum_odd_reg, sgl);
        end
        else
        begin
            sum_even_next = add_mod10(sum_even_reg, sgl);
            sum_odd_next = add_mod10(sum_odd_reg, dbl);
        end
        count_next = (count_reg < COUNT_MAX) ? count_reg + COUNT_W'(1) : count_reg;
    end

    // Length, prefix and checksum checks, first failure wins.
    always_comb
    begin
        prefix_ok = (first_next == PFX_VISA) || (first_next == PFX_MC) ||
                    (first_next == PFX_DISC) ||
                    ((first_next == PFX_AMEX_HI) && (second_next == PFX_AMEX_LO));
        chk = count_next[0] ? sum_odd_next : sum_even_next;
        if ((count_next < LEN_MIN) || (count_next > LEN_MAX))
        begin
            status = ST_BAD_LEN;
        end
        else if (!prefix_ok)
        begin
            status = ST_BAD_PREFIX;
        end
        else if (chk != '0)
        begin
            status = ST_BAD_SUM;
        end
        else
        begin
            status = ST_OK;
        end
        result.valid_res = (status == ST_OK);
        result.status = status;
    end

    // State returns to zero once a number is closed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            first_reg <= '0;
            second_reg <= '0;
            sum_even_reg <= '0;
            sum_odd_reg <= '0;
        end
        else if (fire)
        begin
            if (is_last)
            begin
                count_reg <= '0;
                first_reg <= '0;
                second_reg <= '0;
                sum_even_reg <= '0;
                sum_odd_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
                first_reg <= first_next;
                second_reg <= second_next;
                sum_even_reg <= sum_even_next;
                sum_odd_reg <= sum_odd_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/card_number_luhn_check.sv
// Card number checker: one decimal digit per beat, Luhn mod 10 with length and prefix checks.
// The last digit passes the input register; its verdict is then held in the result register behind res_valid.
// Throughput: one digit per cycle; the input register stalls only on a last digit
// whose result register is still full and not being taken.
// Reset (rst_n, asynchronous, active low) empties both registers and clears all sums.
// Depends on lch_pkg, lch_in_reg and lch_core.
`timescale 1ns / 1ps
`default_nettype none

module card_number_luhn_check
    import lch_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                digit_valid,
    output logic                     digit_ready,
    input  wire logic [DIGIT_W-1:0]  digit,
    input  wire logic                last,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output logic                     valid_res,
    output logic [STATUS_W-1:0]      status
);

    logic        hold_valid;
    digit_t      hold_digit;
    logic        hold_last;
    logic        advance;
    logic        fire;
    lch_result_t result;

    logic        out_valid_reg;
    lch_result_t out_reg;

    // Only a last digit needs room in the result register.
    assign advance = !hold_last || !out_valid_reg || res_ready;
    assign fire = hold_valid && advance;

    lch_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready),
        .digit       (digit),
        .last        (last),
        .advance     (advance),
        .hold_valid  (hold_valid),
        .hold_digit  (hold_digit),
        .hold_last   (hold_last)
    );

    lch_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .d       (hold_digit),
        .is_last (hold_last),
        .result  (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && hold_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && hold_last)
        begin
            out_reg <= result;
        end
    end

    assign res_valid = out_valid_reg;
    assign valid_res = out_reg.valid_res;
    assign status = out_reg.status;

endmodule

`default_nettype wire

>>> tb/card_number_luhn_check_test.sv
// Self-checking testbench for card_number_luhn_check: digit beats in, one verdict per number out.
// Depends on lch_pkg for widths, status codes and prefix digits; uses no files or arguments.
`timescale 1ns / 1ps

module card_number_luhn_check_test;
    import lch_pkg::*;

    localparam int unsigned ITEM_TARGET = 900;
    localparam int unsigned MAX_DIGITS = 40;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned LONG_STALL = 300;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned MAX_REPORTS = 10;

    // How the leading digits of a generated number are chosen.
    typedef enum int unsigned {
        LEAD_4,
        LEAD_5,
        LEAD_6,
        LEAD_37,
        LEAD_3X,
        LEAD_ANY
    } lead_e;

    // Tracks the running Luhn state and holds the verdicts still owed by the block.
    class luhn_scoreboard;
        logic [COUNT_W-1:0] seen;
        digit_t lead_digit;
        digit_t next_digit;
        digit_t sum_even_dbl;
        digit_t sum_odd_dbl;
        lch_result_t verdict_q[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned by_status[4];

        function new();
            clear_number();
            mismatches = 0;
            checked = 0;
            foreach (by_status[i])
            begin
                by_status[i] = 0;
            end
        endfunction

        function void clear_number();
            seen = '0;
            lead_digit = '0;
            next_digit = '0;
            sum_even_dbl = '0;
            sum_odd_dbl = '0;
        endfunction

        // Doubles a digit, sums the decimal digits of anything above nine, reduces modulo 10.
        function digit_t fold_doubled(input digit_t d);
            int unsigned n;
            n = 2 * d;
            if (n > 9)
            begin
                n = n / 10 + n % 10;
            end
            return digit_t'(n % 10);
        endfunction

        function digit_t fold_plain(input digit_t d);
            return digit_t'(d % 10);
        endfunction

        function digit_t add_mod10(input digit_t a, input digit_t b);
            return digit_t'((int'(a) + int'(b)) % 10);
        endfunction

        function int unsigned pending();
            return verdict_q.size();
        endfunction

        // Called for every accepted digit beat; a last beat queues the verdict.
        function void note_digit(input digit_t d, input logic is_last);
            lch_result_t verdict;
            logic prefix_ok;
            digit_t chk;
            if (seen == 0)
            begin
                lead_digit = d;
            end
            if (seen == 1)
            begin
                next_digit = d;
            end
            // Both doubling patterns are tracked, as the length is known only at the end.
            if (!seen[0])
            begin
                sum_even_dbl = add_mod10(sum_even_dbl, fold_doubled(d));
                sum_odd_dbl = add_mod10(sum_odd_dbl, fold_plain(d));
            end
            else
            begin
                sum_even_dbl = add_mod10(sum_even_dbl, fold_plain(d));
                sum_odd_dbl = add_mod10(sum_odd_dbl, fold_doubled(d));
            end
            if (seen != COUNT_MAX)
            begin
                seen = seen + 1'b1;
            end
            if (is_last)
            begin
                prefix_ok = lead_digit == PFX_VISA || lead_digit == PFX_MC ||
                            lead_digit == PFX_DISC ||
                            (lead_digit == PFX_AMEX_HI && next_digit == PFX_AMEX_LO);
                chk = seen[0] ? sum_odd_dbl : sum_even_dbl;
                if (seen < LEN_MIN || seen > LEN_MAX)
                begin
                    verdict.status = ST_BAD_LEN;
                end
                else if (!prefix_ok)
                begin
                    verdict.status = ST_BAD_PREFIX;
                end
                else if (chk != 0)
                begin
                    verdict.status = ST_BAD_SUM;
                end
                else
                begin
                    verdict.status = ST_OK;
                end
                verdict.valid_res = (verdict.status == ST_OK);
                verdict_q.push_back(verdict);
                clear_number();
            end
        endfunction

        function void note_failure(input string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
        endfunction

        // Called for every accepted result beat.
        function void check_result(input logic v, input logic [STATUS_W-1:0] s);
            lch_result_t want;
            if (verdict_q.size() == 0)
            begin
                note_failure($sformatf("unexpected result: valid_res=%0b status=%0d", v, s));
                return;
            end
            want = verdict_q.pop_front();
            checked++;
            by_status[want.status]++;
            if (v !== want.valid_res || s !== want.status)
            begin
                note_failure($sformatf(
                    "number %0d: expected valid_res=%0b status=%0d, got valid_res=%0b status=%0d",
                    checked, want.valid_res, want.status, v, s));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic digit_valid = 1'b0;
    logic digit_ready;
    digit_t digit = '0;
    logic last = 1'b0;
    logic res_valid;
    logic res_ready = 1'b0;
    logic valid_res;
    logic [STATUS_W-1:0] status;

    luhn_scoreboard sb = new();
    int unsigned digits_sent = 0;
    int unsigned idle_cycles = 0;

    card_number_luhn_check u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready),
        .digit       (digit),
        .last        (last),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .valid_res   (valid_res),
        .status      (status)
    );

    always #5 clk = ~clk;

    // Idle lengths: mostly none or short, now and then long.
    function automatic int unsigned pick_gap(input bit no_gaps);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // Offers one digit beat, holds it until taken, then idles for a random gap.
    task automatic send_digit(input digit_t d, input logic is_last, input bit no_gaps);
        int unsigned gap;
        bit taken;
        digit_valid <= 1'b1;
        digit <= d;
        last <= is_last;
        // Ready is sampled mid-cycle, where it already holds the value seen at the next edge.
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = digit_ready;
            @(posedge clk);
        end
        sb.note_digit(d, is_last);
        digits_sent++;
        gap = pick_gap(no_gaps);
        if (gap > 0)
        begin
            digit_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lowers valid and waits until every owed verdict has come back.
    task automatic wait_all_results();
        digit_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Builds a number of the given length and prefix, optionally with a correct check digit.
    task automatic send_number(input int unsigned len, input lead_e lead, input bit make_valid,
                               input bit wild, input bit no_gaps);
        digit_t nums[MAX_DIGITS];
        int unsigned s;
        for (int unsigned i = 0; i < len; i++)
        begin
            nums[i] = (wild && $urandom_range(0, 4) == 0) ? digit_t'($urandom_range(10, 15))
                                                          : digit_t'($urandom_range(0, 9));
        end
        case (lead)
            LEAD_4: nums[0] = PFX_VISA;
            LEAD_5: nums[0] = PFX_MC;
            LEAD_6: nums[0] = PFX_DISC;
            LEAD_37:
            begin
                nums[0] = PFX_AMEX_HI;
                if (len > 1)
                begin
                    nums[1] = PFX_AMEX_LO;
                end
            end
            LEAD_3X:
            begin
                nums[0] = PFX_AMEX_HI;
                if (len > 1 && nums[1] == PFX_AMEX_LO)
                begin
                    nums[1] = digit_t'($urandom_range(0, 6));
                end
            end
            default: ;
        endcase
        // The check digit is always added undoubled; doubling falls where i and len share parity.
        if (make_valid)
        begin
            s = 0;
            for (int unsigned i = 0; i + 1 < len; i++)
            begin
                s = (s + ((i % 2 == len % 2) ? sb.fold_doubled(nums[i])
                                             : sb.fold_plain(nums[i]))) % 10;
            end
            nums[len-1] = digit_t'((10 - s) % 10);
        end
        for (int unsigned i = 0; i < len; i++)
        begin
            send_digit(nums[i], i + 1 == len, no_gaps);
        end
    endtask

    // Stimulus: reset, a few fixed numbers, then random numbers with periodic pauses.
    initial
    begin : stimulus
        int unsigned numbers;
        int unsigned r;
        int unsigned len;
        numbers = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-digit numbers at both digit extremes.
        send_digit(4'd15, 1'b1, 1'b1);
        send_digit(4'd0, 1'b1, 1'b0);
        // A valid 13-digit number starting with 4.
        for (int unsigned i = 0; i < 13; i++)
        begin
            send_digit((i == 0) ? PFX_VISA : ((i == 12) ? digit_t'(6) : digit_t'(0)),
                       i == 12, 1'b0);
        end
        // A short number with a 37 prefix and digits above nine.
        send_digit(PFX_AMEX_HI, 1'b0, 1'b1);
        send_digit(PFX_AMEX_LO, 1'b0, 1'b1);
        send_digit(4'd12, 1'b0, 1'b1);
        send_digit(4'd14, 1'b0, 1'b1);
        send_digit(4'd9, 1'b1, 1'b1);
        wait_all_results();

        while (digits_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                len = $urandom_range(1, 12);
            end
            else if (r < 88)
            begin
                len = $urandom_range(13, 16);
            end
            else if (r < 96)
            begin
                len = $urandom_range(17, 20);
            end
            else
            begin
                len = $urandom_range(30, MAX_DIGITS);
            end
            send_number(len, lead_e'($urandom_range(0, 5)), $urandom_range(0, 3) != 0,
                        $urandom_range(0, 9) == 0, $urandom_range(0, 4) == 0);
            numbers++;
            if (numbers % 15 == 0)
            begin
                wait_all_results();
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d digit beats; checked %0d numbers: %0d ok, %0d bad length,",
                 digits_sent, sb.checked, sb.by_status[ST_OK], sb.by_status[ST_BAD_LEN]);
        $display("%0d bad prefix, %0d bad checksum; %0d mismatches.",
                 sb.by_status[ST_BAD_PREFIX], sb.by_status[ST_BAD_SUM], sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("card_number_luhn_check_test: PASS");
        end
        else
        begin
            $display("card_number_luhn_check_test: FAIL");
        end
        $finish;
    end

    // Result side: random ready bursts, with two long hold-offs so the block backs up.
    initial
    begin : result_sink
        int unsigned burst;
        int unsigned gap;
        bit first_stall_done;
        bit second_stall_done;
        first_stall_done = 1'b0;
        second_stall_done = 1'b0;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if ((!first_stall_done && sb.checked >= 10) ||
                (!second_stall_done && sb.checked >= 40))
            begin
                if (first_stall_done)
                begin
                    second_stall_done = 1'b1;
                end
                first_stall_done = 1'b1;
                res_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
                burst = $urandom_range(1, 30);
                repeat (burst) @(posedge clk);
                gap = pick_gap($urandom_range(0, 4) == 0);
                if (gap > 0)
                begin
                    res_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // Checks every result beat against the oldest owed verdict.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            sb.check_result(valid_res, status);
        end
    end

    // Ends the run if neither side moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (digit_valid && digit_ready) || (res_valid && res_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles.", IDLE_LIMIT);
            $display("card_number_luhn_check_test: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
